### sv/psnm_pkg.sv
// Shared types and constants for the nearest-point store.
package psnm_pkg;

	typedef enum logic [1:0] {
		CMD_INSERT  = 2'd0,
		CMD_REMOVE  = 2'd1,
		CMD_SHIFT   = 2'd2,
		CMD_NEAREST = 2'd3
	} cmd_t;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_DUP      = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_EMPTY    = 3'd4;

	localparam int IN_W = 16;

	// Command as it sits in the queue between front and back
	typedef struct packed {
		cmd_t             cmd;
		logic [IN_W-1:0]  px;
		logic [IN_W-1:0]  py;
	} cmd_item_t;

endpackage

### sv/psnm_front.sv
// Front end: two-entry command queue between the input and the sequencer.
module psnm_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  psnm_pkg::cmd_item_t   in_item,
	output logic                  q_valid,
	input  logic                  q_ready,
	output psnm_pkg::cmd_item_t   q_item
);
	import psnm_pkg::*;

	cmd_item_t  mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = mem_q[rp_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	// queue payload
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= in_item;
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (pop)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

### sv/psnm_back.sv
// Back end: sequencer scanning the point memory one entry per cycle.
module psnm_back #(
	parameter int CAPACITY   = 64,
	parameter int COORD_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	output logic                  q_ready,
	input  psnm_pkg::cmd_item_t   q_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            status,
	output logic [15:0]           nearest_x,
	output logic [15:0]           nearest_y,
	output logic [16:0]           distance,
	output logic [6:0]            point_count,
	output logic                  store_empty
);
	import psnm_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int CB = COORD_BITS;
	localparam int DW = CB + 1;

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_LAST, S_MOVE, S_DONE} state_t;

	state_t          state_q;
	logic [2*CB-1:0] mem [CAPACITY];
	logic [2*CB-1:0] rd_q;
	cmd_t            cmd_q;
	logic [CB-1:0]   px_q, py_q;
	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   idx_q;    // address issued
	logic [CW-1:0]   cidx_q;   // address of rd_q
	logic            rdv_q;
	logic            found_q;
	logic [DW-1:0]   bd_q;
	logic [2*CB-1:0] best_q;

	logic            we;
	logic [AW-1:0]   waddr;
	logic [2*CB-1:0] wdata;
	logic [AW-1:0]   raddr;

	// coordinate wrap of the 16-bit input fields
	function automatic logic [CB-1:0] to_coord(input logic [15:0] v);
		logic [47:0] s;
		s = {{32{v[15]}}, v};
		return s[CB-1:0];
	endfunction

	function automatic logic [15:0] to_out(input logic [CB-1:0] v);
		logic [47:0] s;
		s = {{(48-CB){v[CB-1]}}, v};
		return s[15:0];
	endfunction

	// Manhattan distance of the entry being read
	logic signed [CB:0] dx, dy;
	logic [CB:0]        ax, ay;
	logic [DW-1:0]      d;
	logic [CB-1:0]      rx, ry;
	assign rx = rd_q[2*CB-1:CB];
	assign ry = rd_q[CB-1:0];
	assign dx = $signed({px_q[CB-1], px_q}) - $signed({rx[CB-1], rx});
	assign dy = $signed({py_q[CB-1], py_q}) - $signed({ry[CB-1], ry});
	assign ax = dx[CB] ? -dx : dx;
	assign ay = dy[CB] ? -dy : dy;
	assign d  = ax + ay;

	logic match;
	assign match = rdv_q && (rd_q == {px_q, py_q});

	assign q_ready = (state_q == S_IDLE) && !out_valid;
	assign raddr   = idx_q[AW-1:0];

	// memory
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	// write port: append, shifted copy or gap close
	always_comb begin
		we    = 1'b0;
		waddr = cidx_q[AW-1:0];
		wdata = rd_q;
		if (state_q == S_LAST && cmd_q == CMD_INSERT && !found_q
		    && cnt_q != CW'(CAPACITY)) begin
			we    = 1'b1;
			waddr = cnt_q[AW-1:0];
			wdata = {px_q, py_q};
		end else if (rdv_q && cmd_q == CMD_SHIFT) begin
			we    = 1'b1;
			wdata = {rx + px_q, ry + py_q};
		end else if (rdv_q && cmd_q == CMD_REMOVE && found_q) begin
			we    = 1'b1;
			waddr = AW'(cidx_q - 1'b1);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			out_valid <= 1'b0;
			rdv_q     <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					rdv_q <= 1'b0;
					if (q_valid && q_ready) begin
						cmd_q   <= q_item.cmd;
						px_q    <= to_coord(q_item.px);
						py_q    <= to_coord(q_item.py);
						idx_q   <= '0;
						found_q <= 1'b0;
						bd_q    <= '1;
						state_q <= (cnt_q == '0) ? S_LAST : S_SCAN;
					end
				end
				S_SCAN: begin
					rdv_q  <= 1'b1;
					cidx_q <= idx_q;
					idx_q  <= idx_q + 1'b1;
					if (idx_q + 1'b1 == cnt_q)
						state_q <= S_MOVE;
					if (match)
						found_q <= 1'b1;
					if (rdv_q && d < bd_q) begin
						bd_q   <= d;
						best_q <= rd_q;
					end
				end
				S_MOVE: begin
					// evaluate the final entry
					rdv_q   <= 1'b0;
					state_q <= S_LAST;
					if (match)
						found_q <= 1'b1;
					if (rdv_q && d < bd_q) begin
						bd_q   <= d;
						best_q <= rd_q;
					end
				end
				S_LAST: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					out_valid   <= 1'b1;
					nearest_x   <= '0;
					nearest_y   <= '0;
					distance    <= '0;
					status      <= ST_OK;
					state_q     <= S_IDLE;
					case (cmd_q)
						CMD_INSERT: begin
							if (found_q)
								status <= ST_DUP;
							else if (cnt_q == CW'(CAPACITY))
								status <= ST_FULL;
							else
								cnt_q <= cnt_q + 1'b1;
						end
						CMD_REMOVE: begin
							if (!found_q)
								status <= ST_NOTFOUND;
							else
								cnt_q <= cnt_q - 1'b1;
						end
						CMD_NEAREST: begin
							if (cnt_q == '0)
								status <= ST_EMPTY;
							else begin
								nearest_x <= to_out(best_q[2*CB-1:CB]);
								nearest_y <= to_out(best_q[CB-1:0]);
								distance  <= 17'(bd_q);
							end
						end
						default: ;
					endcase
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// count reflects the update made above
	logic [CW-1:0] cnt_out;
	assign cnt_out     = cnt_q;
	assign point_count = 7'(cnt_out);
	assign store_empty = (cnt_out == '0);

endmodule

### sv/point_set_nearest_manhattan_top.sv
// Top level of the ordered point store with Manhattan nearest query.
// Each command scans the stored points one entry per cycle; the back end takes no new
// command until its result has been taken, and the queue takes up to two more
// meanwhile.
// Reset: arst_n clears the count and all control; point memory is not cleared.
module point_set_nearest_manhattan_top #(
	parameter int CAPACITY   = 64,
	parameter int COORD_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         command,
	input  logic signed [15:0] point_x,
	input  logic signed [15:0] point_y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         status,
	output logic signed [15:0] nearest_x,
	output logic signed [15:0] nearest_y,
	output logic [16:0]        distance,
	output logic [6:0]         point_count,
	output logic               store_empty
);
	import psnm_pkg::*;

	cmd_item_t in_item, q_item;
	logic      q_valid, q_ready;

	assign in_item.cmd = cmd_t'(command);
	assign in_item.px  = point_x;
	assign in_item.py  = point_y;

	psnm_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_item,
		.q_valid, .q_ready, .q_item
	);

	psnm_back #(.CAPACITY(CAPACITY), .COORD_BITS(COORD_BITS)) u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_item,
		.out_valid, .out_ready, .status, .nearest_x, .nearest_y,
		.distance, .point_count, .store_empty
	);

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (store_empty == (point_count == 7'd0)))
		else $error("empty flag disagrees with count");
	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(point_count) <= CAPACITY))
		else $error("count above capacity");
	a_qdist: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (distance == 17'd0))
		else $error("distance on a failed command");

endmodule

### tb/point_set_nearest_manhattan_top_tb.sv
// Self-checking testbench for the ordered point store with Manhattan nearest query.
`timescale 1ns / 1ps
module point_set_nearest_manhattan_top_tb;
	import psnm_pkg::*;

	localparam int CAP = 64;
	localparam int WATCH_LIMIT = 20000;

	typedef struct {
		cmd_t             cmd;
		logic [15:0]      px;
		logic [15:0]      py;
	} cmd_rec_t;

	typedef struct {
		logic [2:0]  st;
		logic [15:0] nx;
		logic [15:0] ny;
		logic [16:0] dlen;
		logic [6:0]  cnt;
		logic        emp;
	} answer_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         command = '0;
	logic signed [15:0] point_x = '0;
	logic signed [15:0] point_y = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [2:0]         status;
	logic signed [15:0] nearest_x;
	logic signed [15:0] nearest_y;
	logic [16:0]        distance;
	logic [6:0]         point_count;
	logic               store_empty;

	point_set_nearest_manhattan_top dut (.*);

	always #5 clk = ~clk;

	// predictor state
	logic [15:0] shadow_x [CAP];
	logic [15:0] shadow_y [CAP];
	int          shadow_n = 0;

	cmd_rec_t pending_cmds [$];
	answer_t  awaited [$];
	int       errors = 0;
	bit       calm = 0;       // no idling in the last part
	bit       hold_rx = 0;    // long receiver hold-off request
	bit       hold_tx = 0;    // sender pause
	int       rx_gap = 0;
	int       tx_gap = 0;
	int       quiet = 0;

	function automatic int find_pt(logic [15:0] x, logic [15:0] y);
		for (int i = 0; i < shadow_n; i++)
			if (shadow_x[i] == x && shadow_y[i] == y) return i;
		return -1;
	endfunction

	function automatic logic [16:0] span(logic [15:0] a, logic [15:0] b);
		int d;
		d = int'($signed(a)) - int'($signed(b));
		return (d < 0) ? 17'(-d) : 17'(d);
	endfunction

	// apply one command to the shadow store and give its answer
	function automatic answer_t apply_cmd(cmd_rec_t c);
		answer_t a;
		int idx;
		logic [16:0] d, bd;
		a = '{ST_OK, 16'd0, 16'd0, 17'd0, 7'd0, 1'b0};
		case (c.cmd)
			CMD_INSERT: begin
				if (find_pt(c.px, c.py) >= 0) a.st = ST_DUP;
				else if (shadow_n >= CAP) a.st = ST_FULL;
				else begin
					shadow_x[shadow_n] = c.px;
					shadow_y[shadow_n] = c.py;
					shadow_n++;
				end
			end
			CMD_REMOVE: begin
				idx = find_pt(c.px, c.py);
				if (idx < 0) a.st = ST_NOTFOUND;
				else begin
					for (int i = idx; i + 1 < shadow_n; i++) begin
						shadow_x[i] = shadow_x[i+1];
						shadow_y[i] = shadow_y[i+1];
					end
					shadow_n--;
				end
			end
			CMD_SHIFT: begin
				for (int i = 0; i < shadow_n; i++) begin
					shadow_x[i] = shadow_x[i] + c.px;
					shadow_y[i] = shadow_y[i] + c.py;
				end
			end
			default: begin
				if (shadow_n == 0) a.st = ST_EMPTY;
				else begin
					idx = 0;
					bd = span(c.px, shadow_x[0]) + span(c.py, shadow_y[0]);
					for (int i = 1; i < shadow_n; i++) begin
						d = span(c.px, shadow_x[i]) + span(c.py, shadow_y[i]);
						if (d < bd) begin
							bd = d;
							idx = i;
						end
					end
					a.nx = shadow_x[idx];
					a.ny = shadow_y[idx];
					a.dlen = bd;
				end
			end
		endcase
		a.cnt = 7'(shadow_n);
		a.emp = (shadow_n == 0);
		return a;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	task automatic push(cmd_t c, logic [15:0] x, logic [15:0] y);
		cmd_rec_t r;
		r.cmd = c;
		r.px = x;
		r.py = y;
		pending_cmds.push_back(r);
	endtask

	// driver
	always @(posedge clk) begin
		bit fire;
		bit v_next;
		if (arst_n) begin
			fire = in_valid && in_ready;
			v_next = in_valid && !fire;
			if (fire)
				awaited.push_back(apply_cmd('{cmd_t'(command), point_x, point_y}));
			if (!v_next) begin
				if (tx_gap > 0) tx_gap--;
				else if (!hold_tx && pending_cmds.size() > 0) begin
					if (!calm && $urandom_range(0, 5) == 0) begin
						tx_gap = $urandom_range(1, 4);
					end else begin
						cmd_rec_t r;
						r = pending_cmds.pop_front();
						command <= r.cmd;
						point_x <= r.px;
						point_y <= r.py;
						v_next = 1'b1;
					end
				end
			end
			in_valid <= v_next;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				answer_t w;
				if (awaited.size() == 0) report("unexpected result", 32'(status), 0);
				else begin
					w = awaited.pop_front();
					if (status !== w.st) report("status", 32'(status), 32'(w.st));
					if (nearest_x !== w.nx)
						report("nearest_x", {16'd0, nearest_x}, {16'd0, w.nx});
					if (nearest_y !== w.ny)
						report("nearest_y", {16'd0, nearest_y}, {16'd0, w.ny});
					if (distance !== w.dlen)
						report("distance", 32'(distance), 32'(w.dlen));
					if (point_count !== w.cnt)
						report("point_count", 32'(point_count), 32'(w.cnt));
					if (store_empty !== w.emp)
						report("store_empty", 32'(store_empty), 32'(w.emp));
				end
			end
			if (hold_rx) out_ready <= 1'b0;
			else if (rx_gap > 0) begin
				rx_gap--;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				rx_gap = $urandom_range(1, 4);
				out_ready <= 1'b0;
			end else out_ready <= 1'b1;
		end
	end

	// watchdog on cycles without any accepted item
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
			else quiet++;
			if (quiet >= WATCH_LIMIT) begin
				$display("point_set_nearest_manhattan_top: mismatch");
				$finish;
			end
		end
	end

	function automatic logic [15:0] near_coord(logic [15:0] base);
		return base + 16'($urandom_range(0, 6)) - 16'd3;
	endfunction

	initial begin
		logic [15:0] rx, ry;
		int k;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty cases, extremes, duplicates, removal gaps
		push(CMD_NEAREST, 16'h0000, 16'h0000);
		push(CMD_REMOVE, 16'h1234, 16'h4321);
		push(CMD_SHIFT, 16'h0005, 16'hFFFB);
		push(CMD_INSERT, 16'h7FFF, 16'h7FFF);
		push(CMD_INSERT, 16'h8000, 16'h8000);
		push(CMD_INSERT, 16'h7FFF, 16'h7FFF);
		push(CMD_NEAREST, 16'h8000, 16'h7FFF);
		push(CMD_NEAREST, 16'h8000, 16'h8000);
		push(CMD_INSERT, 16'h0000, 16'h0000);
		push(CMD_INSERT, 16'h0002, 16'h0000);
		push(CMD_NEAREST, 16'h0001, 16'h0000);
		push(CMD_SHIFT, 16'h0001, 16'hFFFF);
		push(CMD_NEAREST, 16'h8001, 16'h7FFF);
		push(CMD_REMOVE, 16'h0001, 16'hFFFF);
		push(CMD_REMOVE, 16'h0001, 16'hFFFF);
		push(CMD_NEAREST, 16'h0000, 16'h0000);
		push(CMD_SHIFT, 16'hFFFF, 16'hFFFF);
		push(CMD_SHIFT, 16'h8000, 16'h8000);
		push(CMD_NEAREST, 16'h5555, 16'hAAAA);
		wait (pending_cmds.size() == 0 && awaited.size() == 0 && !in_valid);

		// fill to capacity, then full and duplicate-when-full inserts
		for (int i = 0; i < CAP + 2; i++) push(CMD_INSERT, 16'(i * 37), 16'(-i * 11));
		push(CMD_INSERT, 16'd37, 16'hFFF5);
		push(CMD_NEAREST, 16'd100, 16'hFFF0);
		// receiver hold-off so the input stalls
		hold_rx = 1;
		repeat (400) @(posedge clk);
		hold_rx = 0;
		wait (pending_cmds.size() == 0 && awaited.size() == 0 && !in_valid);
		for (int i = 0; i < CAP; i += 2) push(CMD_REMOVE, 16'(i * 37), 16'(-i * 11));
		push(CMD_NEAREST, 16'hFFFF, 16'h0000);

		// random: clustered points so hits and ties are common
		rx = 16'($urandom);
		ry = 16'($urandom);
		for (int n = 0; n < 280; n++) begin
			k = $urandom_range(0, 99);
			if (n == 140) begin
				wait (pending_cmds.size() == 0);
				hold_tx = 1;
				wait (awaited.size() == 0 && !in_valid);
				hold_tx = 0;
			end
			if (n == 240) calm = 1;
			if (k < 5) push(cmd_t'($urandom_range(0, 3)), 16'($urandom), 16'($urandom));
			else if (k < 40) push(CMD_INSERT, near_coord(rx), near_coord(ry));
			else if (k < 60) push(CMD_REMOVE, near_coord(rx), near_coord(ry));
			else if (k < 68) begin
				if ($urandom_range(0, 1)) push(CMD_SHIFT, 16'($urandom), 16'($urandom));
				else push(CMD_SHIFT, 16'($urandom_range(0, 4)) - 16'd2,
					16'($urandom_range(0, 4)) - 16'd2);
			end else push(CMD_NEAREST, near_coord(rx), near_coord(ry));
			if ($urandom_range(0, 40) == 0) begin
				rx = 16'($urandom);
				ry = 16'($urandom);
			end
		end

		wait (pending_cmds.size() == 0 && awaited.size() == 0 && !in_valid);
		repeat (CAP + 10) @(posedge clk);
		if (errors == 0 && awaited.size() == 0)
			$display("point_set_nearest_manhattan_top: match");
		else
			$display("point_set_nearest_manhattan_top: mismatch");
		$finish;
	end
endmodule
